// ----- rtl/core/rphd_pkg.sv -----
// Package for the RSSI proximity haptic driver: action and register codes,
// fixed-point constants and the constant lookup tables built at elaboration.
// Depends on nothing; used by rssi_proximity_haptic_driver.
package rphd_pkg;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_PACKET = 2'd1,
    ACT_PULSE  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  localparam logic REG_INTENSITY = 1'b0;
  localparam logic REG_CONSTANT  = 1'b1;

  localparam int STEP_MAX   = 19;
  localparam int STEP_W     = 5;
  localparam int LEVEL_W    = 7;
  localparam int TARGET_W   = 10;
  localparam int FACTOR_W   = 8;
  localparam int STEP_IDX_N = 111;
  localparam int STEP_IDX_W = 7;
  localparam int MS_W       = 11;

  localparam int DIV_W       = 21;
  localparam int RECIP_W     = 21;
  localparam int DIV_PROD_W  = 42;
  localparam int RECIP_SHIFT = 24;

  localparam logic [RECIP_W-1:0] RECIP_10 = 21'd1677722;
  localparam logic [RECIP_W-1:0] RECIP_95 = 21'd176603;

  localparam logic signed [15:0] RSSI_RESET     = -16'sd25600;
  localparam logic [17:0]        INTERVAL_RESET = 18'd153600;
  localparam logic [4:0]         STEP_RESET     = 5'd19;

  localparam logic signed [21:0] RSSI_BIAS  = 22'sd655365;
  localparam logic signed [21:0] RSSI_UNB   = 22'sd65536;
  localparam logic signed [21:0] RSSI_QMAX  = 22'sd32767;
  localparam logic signed [21:0] RSSI_QMIN  = -22'sd32768;

  localparam logic [31:0] PULSE_MS       = 32'd200;
  localparam logic [31:0] TIMEOUT_MS     = 32'd5000;
  localparam logic [31:0] TOGGLE_HOLD_MS = 32'd200;
  localparam logic [MS_W-1:0] ON_MIN_MS  = 11'd60;
  localparam logic [MS_W-1:0] OFF_MIN_MS = 11'd40;

  function automatic logic [STEP_IDX_N*STEP_W-1:0] build_step_lut();
    logic [STEP_IDX_N*STEP_W-1:0] t;
    int v;
    t = '0;
    for (int i = 0; i < STEP_IDX_N; i++) begin
      v = (i * 38 + 110) / 220;
      t[i*STEP_W +: STEP_W] = v[STEP_W-1:0];
    end
    return t;
  endfunction

  function automatic logic [128*LEVEL_W-1:0] build_drive_lut();
    logic [128*LEVEL_W-1:0] t;
    int s;
    int b;
    t = '0;
    for (int i = 0; i < 128; i++) begin
      s = i % 32;
      if (s > STEP_MAX) s = STEP_MAX;
      b = 127 - (s * 200 + 19) / 38;
      if (b < 20) b = 20;
      if (b > 127) b = 127;
      case (i / 32)
        0: b = (b * 40 + 50) / 100;
        1: b = (b * 65 + 50) / 100;
        2: b = (b * 85 + 50) / 100;
        default: b = b;
      endcase
      if (b < 10) b = 10;
      if (b > 127) b = 127;
      t[i*LEVEL_W +: LEVEL_W] = b[LEVEL_W-1:0];
    end
    return t;
  endfunction

  function automatic logic [32*TARGET_W-1:0] build_target_lut();
    logic [32*TARGET_W-1:0] t;
    int s;
    int v;
    t = '0;
    for (int i = 0; i < 32; i++) begin
      s = (i > STEP_MAX) ? STEP_MAX : i;
      v = 120 + (s * 1360 + 19) / 38;
      if (v > 800) v = 800;
      t[i*TARGET_W +: TARGET_W] = v[TARGET_W-1:0];
    end
    return t;
  endfunction

  function automatic logic [32*FACTOR_W-1:0] build_factor_lut();
    logic [32*FACTOR_W-1:0] t;
    int s;
    int v;
    t = '0;
    for (int i = 0; i < 32; i++) begin
      s = (i > STEP_MAX) ? STEP_MAX : i;
      v = 152 - 5 * s;
      t[i*FACTOR_W +: FACTOR_W] = v[FACTOR_W-1:0];
    end
    return t;
  endfunction

  localparam logic [STEP_IDX_N*STEP_W-1:0] STEP_LUT   = build_step_lut();
  localparam logic [128*LEVEL_W-1:0]       DRIVE_LUT  = build_drive_lut();
  localparam logic [32*TARGET_W-1:0]       TARGET_LUT = build_target_lut();
  localparam logic [32*FACTOR_W-1:0]       FACTOR_LUT = build_factor_lut();

endpackage

// ----- rtl/core/rssi_proximity_haptic_driver.sv -----
// Top level of the RSSI proximity haptic driver: smoothing, distance mapping,
// pulse and constant-vibration sequencing around one shared reciprocal multiplier.
// Depends on rphd_pkg.
//
// One transaction is worked on at a time; in_stall stays high from acceptance
// until the result is registered. A packet walks S_RSSI_DIV, S_RSSI_STEP and
// S_FINISH; a tick walks S_TICK_PULSE and S_TICK_MODE, and in constant mode
// without timeout also S_INT_DIV, S_ON_MUL, S_ON_LOAD, S_ON_DIV and S_TOGGLE,
// before S_FINISH; a pulse request or unknown action goes straight to S_FINISH,
// which waits while out_stall holds the output register. The shared reciprocal
// multiplier serves the RSSI average, the interval average and the on-time in
// turn. The result sits in an output register, so a finished result does not
// block the next acceptance once it has been registered. Configuration writes
// take effect at once and belong between transactions.
module rssi_proximity_haptic_driver (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        action,
  input  logic [31:0]       now_ms,
  input  logic signed [8:0] rssi_dbm,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              motor_write,
  output logic [6:0]        motor_level,
  output logic              vibe_active,
  output logic [4:0]        distance_step,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [1:0]        cfg_data
);

  typedef enum logic [10:0] {
    S_IDLE       = 11'b000_0000_0001,
    S_RSSI_DIV   = 11'b000_0000_0010,
    S_RSSI_STEP  = 11'b000_0000_0100,
    S_TICK_PULSE = 11'b000_0000_1000,
    S_TICK_MODE  = 11'b000_0001_0000,
    S_INT_DIV    = 11'b000_0010_0000,
    S_ON_MUL     = 11'b000_0100_0000,
    S_ON_LOAD    = 11'b000_1000_0000,
    S_ON_DIV     = 11'b001_0000_0000,
    S_TOGGLE     = 11'b010_0000_0000,
    S_FINISH     = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic [1:0]        intensity_mode;
  logic              constant_feedback;

  logic signed [15:0] smoothed_rssi;
  logic [17:0]        smoothed_interval;
  logic [4:0]         latest_step;
  logic [31:0]        last_reception_time;
  logic [31:0]        pulse_stop_time;
  logic [31:0]        next_toggle_time;
  logic               vibe_on_phase;
  logic               pulse_pending;
  logic [4:0]         pulse_step;
  logic               pulse_running;
  logic [6:0]         level_held;
  logic               wrote;
  logic               timed_out;

  logic [31:0]              item_now;
  logic [24:0]              on_prod;
  logic [rphd_pkg::MS_W-1:0] on_ms;
  logic [rphd_pkg::MS_W-1:0] off_ms;

  logic [rphd_pkg::DIV_W-1:0]      div_num;
  logic [rphd_pkg::RECIP_W-1:0]    div_recip;
  logic [rphd_pkg::DIV_PROD_W-1:0] div_prod;
  logic [rphd_pkg::DIV_W-1:0]      div_quot;

  logic signed [21:0] rssi_x;
  logic signed [21:0] rssi_s;
  logic signed [21:0] rssi_num;
  logic signed [21:0] rssi_val;
  logic signed [15:0] rssi_sat;
  logic [16:0]        rssi_mag;
  logic [16:0]        rssi_mag_rnd;
  logic [7:0]         rssi_k;
  logic [rphd_pkg::STEP_IDX_W-1:0] step_idx;
  logic [4:0]         step_new;

  logic [31:0] pulse_start_time;
  logic [31:0] tick_stop_time;
  logic        tick_run;
  logic        tick_end;
  logic [31:0] since_rx;
  logic        tmo;
  logic [6:0]  pulse_level;
  logic [6:0]  vibe_level;
  logic [rphd_pkg::TARGET_W-1:0] target;
  logic [rphd_pkg::FACTOR_W-1:0] factor;
  logic [rphd_pkg::DIV_W-1:0]    int_num;
  logic [25:0] on_prod_full;
  logic [25:0] on_num_full;
  logic [18:0] whole_full;
  logic [rphd_pkg::MS_W-1:0] whole;
  logic [rphd_pkg::MS_W-1:0] on_raw;
  logic [rphd_pkg::MS_W-1:0] off_raw;
  logic [rphd_pkg::MS_W-1:0] on_ms_new;
  logic [rphd_pkg::MS_W-1:0] off_ms_new;
  logic        toggle_due;
  logic        out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // shared reciprocal multiplier: quotient by a small constant, combinational
  assign div_prod = rphd_pkg::DIV_PROD_W'(div_num) * rphd_pkg::DIV_PROD_W'(div_recip);
  assign div_quot = rphd_pkg::DIV_W'(div_prod[rphd_pkg::DIV_PROD_W-1:rphd_pkg::RECIP_SHIFT]);

  // RSSI average numerator, biased to stay positive
  assign rssi_x   = 22'(rssi_dbm);
  assign rssi_s   = 22'(smoothed_rssi);
  assign rssi_num = (rssi_x <<< 8) + (rssi_s <<< 3) + rssi_s + rphd_pkg::RSSI_BIAS;
  assign rssi_val = $signed({1'b0, div_quot}) - rphd_pkg::RSSI_UNB;

  always_comb begin
    if (rssi_val > rphd_pkg::RSSI_QMAX) begin
      rssi_sat = 16'sh7fff;
    end else if (rssi_val < rphd_pkg::RSSI_QMIN) begin
      rssi_sat = 16'sh8000;
    end else begin
      rssi_sat = rssi_val[15:0];
    end
  end

  assign rssi_mag     = 17'd0 - 17'(smoothed_rssi);
  assign rssi_mag_rnd = rssi_mag + 17'd128;
  assign rssi_k       = rssi_mag_rnd[15:8];

  always_comb begin
    if (!smoothed_rssi[15] || rssi_k < 8'd10) begin
      step_idx = '0;
    end else if (rssi_k > 8'd120) begin
      step_idx = 7'd110;
    end else begin
      step_idx = 7'(rssi_k - 8'd10);
    end
  end

  assign step_new = rphd_pkg::STEP_LUT[step_idx*rphd_pkg::STEP_W +: rphd_pkg::STEP_W];

  // tick: pulse start and stop, timeout
  assign pulse_start_time = item_now + rphd_pkg::PULSE_MS;
  assign tick_stop_time   = pulse_pending ? pulse_start_time : pulse_stop_time;
  assign tick_run         = pulse_running || pulse_pending;
  assign tick_end         = tick_run && (item_now > tick_stop_time);
  assign since_rx         = item_now - last_reception_time;
  assign tmo              = since_rx > rphd_pkg::TIMEOUT_MS;

  assign pulse_level = rphd_pkg::DRIVE_LUT[{intensity_mode, pulse_step}*rphd_pkg::LEVEL_W
                                           +: rphd_pkg::LEVEL_W];
  assign vibe_level  = rphd_pkg::DRIVE_LUT[{intensity_mode, latest_step}*rphd_pkg::LEVEL_W
                                           +: rphd_pkg::LEVEL_W];

  // constant mode: interval average, on and off times
  assign target  = rphd_pkg::TARGET_LUT[latest_step*rphd_pkg::TARGET_W +: rphd_pkg::TARGET_W];
  assign factor  = rphd_pkg::FACTOR_LUT[latest_step*rphd_pkg::FACTOR_W +: rphd_pkg::FACTOR_W];
  assign int_num = (rphd_pkg::DIV_W'(target) << 9)
                 + (rphd_pkg::DIV_W'(smoothed_interval) << 3)
                 + rphd_pkg::DIV_W'(5);

  assign on_prod_full = 26'(smoothed_interval) * 26'(factor);
  assign on_num_full  = {on_prod, 1'b0} + 26'd48640;
  assign whole_full   = 19'(smoothed_interval) + 19'd128;
  assign whole        = whole_full[18:8];
  assign on_raw       = div_quot[rphd_pkg::MS_W-1:0];
  assign off_raw      = (whole >= on_raw) ? whole - on_raw : '0;
  assign on_ms_new    = (on_raw < rphd_pkg::ON_MIN_MS) ? rphd_pkg::ON_MIN_MS : on_raw;
  assign off_ms_new   = (off_raw < rphd_pkg::OFF_MIN_MS) ? rphd_pkg::OFF_MIN_MS : off_raw;
  assign toggle_due   = item_now >= next_toggle_time;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (action)
            rphd_pkg::ACT_TICK:   state_next = S_TICK_PULSE;
            rphd_pkg::ACT_PACKET: state_next = S_RSSI_DIV;
            default:              state_next = S_FINISH;
          endcase
        end
      end
      S_RSSI_DIV:   state_next = S_RSSI_STEP;
      S_RSSI_STEP:  state_next = S_FINISH;
      S_TICK_PULSE: state_next = S_TICK_MODE;
      S_TICK_MODE: begin
        if (timed_out || !constant_feedback) state_next = S_FINISH;
        else state_next = S_INT_DIV;
      end
      S_INT_DIV: state_next = S_ON_MUL;
      S_ON_MUL:  state_next = S_ON_LOAD;
      S_ON_LOAD: state_next = S_ON_DIV;
      S_ON_DIV:  state_next = S_TOGGLE;
      S_TOGGLE:  state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      intensity_mode      <= 2'd0;
      constant_feedback   <= 1'b1;
      smoothed_rssi       <= rphd_pkg::RSSI_RESET;
      smoothed_interval   <= rphd_pkg::INTERVAL_RESET;
      latest_step         <= rphd_pkg::STEP_RESET;
      last_reception_time <= '0;
      pulse_stop_time     <= '0;
      next_toggle_time    <= '0;
      vibe_on_phase       <= 1'b0;
      pulse_pending       <= 1'b0;
      pulse_step          <= '0;
      pulse_running       <= 1'b0;
      level_held          <= '0;
      wrote               <= 1'b0;
      timed_out           <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        if (cfg_index == rphd_pkg::REG_INTENSITY) intensity_mode <= cfg_data;
        else constant_feedback <= cfg_data[0];
      end

      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item_now <= now_ms;
            wrote    <= 1'b0;
            case (action)
              rphd_pkg::ACT_PACKET: begin
                last_reception_time <= now_ms;
                div_num   <= rssi_num[rphd_pkg::DIV_W-1:0];
                div_recip <= rphd_pkg::RECIP_10;
              end
              rphd_pkg::ACT_PULSE: begin
                pulse_step    <= '0;
                pulse_pending <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_RSSI_DIV: begin
          smoothed_rssi <= rssi_sat;
        end
        S_RSSI_STEP: begin
          latest_step <= step_new;
          if (!constant_feedback) begin
            pulse_step    <= step_new;
            pulse_pending <= 1'b1;
          end
        end
        S_TICK_PULSE: begin
          pulse_pending   <= 1'b0;
          pulse_stop_time <= tick_stop_time;
          pulse_running   <= tick_run && !tick_end;
          timed_out       <= tmo;
          if (tick_end) begin
            level_held <= '0;
            wrote      <= 1'b1;
          end else if (pulse_pending) begin
            level_held <= pulse_level;
            wrote      <= 1'b1;
          end
        end
        S_TICK_MODE: begin
          if (timed_out) begin
            if (pulse_running || vibe_on_phase) begin
              level_held    <= '0;
              wrote         <= 1'b1;
              pulse_running <= 1'b0;
              vibe_on_phase <= 1'b0;
            end
            next_toggle_time <= item_now + rphd_pkg::TOGGLE_HOLD_MS;
          end else if (constant_feedback) begin
            div_num   <= int_num;
            div_recip <= rphd_pkg::RECIP_10;
          end
        end
        S_INT_DIV: begin
          smoothed_interval <= div_quot[17:0];
        end
        S_ON_MUL: begin
          on_prod <= on_prod_full[24:0];
        end
        S_ON_LOAD: begin
          div_num   <= rphd_pkg::DIV_W'(on_num_full[25:10]);
          div_recip <= rphd_pkg::RECIP_95;
        end
        S_ON_DIV: begin
          on_ms  <= on_ms_new;
          off_ms <= off_ms_new;
        end
        S_TOGGLE: begin
          if (toggle_due) begin
            wrote <= 1'b1;
            if (vibe_on_phase) begin
              level_held       <= '0;
              vibe_on_phase    <= 1'b0;
              next_toggle_time <= item_now + 32'(off_ms);
            end else begin
              level_held       <= vibe_level;
              vibe_on_phase    <= 1'b1;
              next_toggle_time <= item_now + 32'(on_ms);
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            motor_write   <= wrote;
            motor_level   <= level_held;
            vibe_active   <= vibe_on_phase;
            distance_step <= latest_step;
          end
        end
        default: ;
      endcase
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (latest_step <= 5'd19) && (pulse_step <= 5'd19))
    else $error("distance step out of range");

  a_interval_range: assert property (@(posedge clk) disable iff (rst)
    smoothed_interval <= 18'd204800)
    else $error("smoothed interval above its ceiling");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted a transaction without going busy");

  a_result_on_finish: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_free) |=> (out_valid && state == S_IDLE))
    else $error("finished transaction not registered");

endmodule
